// File: rtl/skdet_pkg.sv
// Shared types, request codes and constants for the sorted key deposit/evaporate table.
package skdet_pkg;

  localparam int NUM_KEYS    = 1024;
  localparam int MAX_ENTRIES = 16;
  localparam int SLOT_W      = 10;
  localparam int IDX_W       = 4;
  localparam int ENT_ADDR_W  = SLOT_W + IDX_W;
  localparam int CNT_W       = 5;

  localparam logic [2:0] REQ_WR_KEY   = 3'd0;
  localparam logic [2:0] REQ_WR_ENTRY = 3'd1;
  localparam logic [2:0] REQ_DEPOSIT  = 3'd2;
  localparam logic [2:0] REQ_GAME_END = 3'd3;
  localparam logic [2:0] REQ_RD_ENTRY = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;

  localparam logic [1:0] CFG_KEY_COUNT = 2'd0;
  localparam logic [1:0] CFG_DECAY     = 2'd1;
  localparam logic [1:0] CFG_INTERVAL  = 2'd2;

  localparam logic [15:0] DEP_LIMIT    = 16'hFFFF;
  localparam logic [15:0] ZERO_DEPOSIT = 16'd10;
  localparam logic [15:0] DECAY_RESET  = 16'd63570;
  localparam logic [7:0]  INTERVAL_RST = 8'd12;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [9:0]  slot;
    logic [3:0]  entry_index;
    logic [63:0] search_key;
    logic [4:0]  entry_count;
    logic [15:0] move_code;
    logic [15:0] weight_in;
    logic [15:0] visits_in;
    logic [15:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        swept;
    logic [31:0] iteration;
    logic [15:0] move_out;
    logic [15:0] weight_out;
    logic [15:0] visits_out;
    logic [15:0] deposit_out;
  } out_item_t;

  // entry word: move, weight, visits, deposit
  typedef struct packed {
    logic [15:0] move;
    logic [15:0] weight;
    logic [15:0] visits;
    logic [15:0] deposit;
  } entry_t;

  // key word: key and its entry count
  typedef struct packed {
    logic [63:0] key;
    logic [4:0]  cnt;
  } key_t;

endpackage

// File: rtl/skdet_ram.sv
// Generic single-port synchronous RAM with registered read.
module skdet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: rtl/sorted_key_deposit_evaporate_table_unit.sv
// Top level: sorted key table with deposit search and evaporation sweep.
// Usage:
//  - Issue a transaction on in_item with start high while busy is low. Exactly
//    one result follows on out_item, marked by out_valid for one cycle.
//  - Configuration: cfg_we, cfg_index, cfg_wdata; write only while idle.
//  - Write key, write entry, out-of-range and game end without sweep finish
//    through S_DONE; read entry finishes through S_RDWAIT.
//  - Deposit: binary search, probes via S_BS_RD, S_BS_WT, S_BS_CMP (at most 11
//    probes for 1024 keys), then S_SC_RD, S_SC_CHK per scanned entry (at most 16).
//  - Sweep: for each slot in use a key read (S_SW_KRD) and a wait (S_SW_KGT),
//    then a read and a write back per owned entry (S_SW_ERD, S_SW_EWR) and a
//    final S_SW_ERD to close the slot.
//  - All stores live in two single-port RAMs (key RAM, entry RAM); each
//    read-modify-write is done by the sequencer, so no accesses overlap.
//  - Reset clears the sequencer, sweep, game and key counts and out_valid, and
//    sets decay/interval defaults; RAM is undefined until written. No clearing pass.
//  - The receiver cannot stall; results are never held.
module sorted_key_deposit_evaporate_table_unit
  import skdet_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RDWAIT = 4'd1;
  localparam logic [3:0] S_BS_RD  = 4'd2;
  localparam logic [3:0] S_BS_CMP = 4'd3;
  localparam logic [3:0] S_SC_RD  = 4'd4;
  localparam logic [3:0] S_SC_CHK = 4'd5;
  localparam logic [3:0] S_SW_KRD = 4'd6;
  localparam logic [3:0] S_SW_KGT = 4'd7;
  localparam logic [3:0] S_SW_ERD = 4'd8;
  localparam logic [3:0] S_SW_EWR = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;
  localparam logic [3:0] S_BS_WT  = 4'd11;

  logic [3:0]  state_r, state_nxt;
  logic [10:0] key_count_r;
  logic [15:0] decay_r;
  logic [7:0]  interval_r;
  logic [7:0]  games_r, games_nxt;
  logic [31:0] iter_r, iter_nxt;
  in_item_t    req_r, req_nxt;
  out_item_t   res_r, res_nxt;
  logic        out_valid_r, out_valid_nxt;

  // binary search bounds (signed range handled by 12 bits)
  logic signed [11:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W:0]     e_r, e_nxt;

  logic                  k_we;
  logic [SLOT_W-1:0]     k_addr;
  key_t                  k_wdata, k_rdata;
  logic                  e_we;
  logic [ENT_ADDR_W-1:0] e_addr;
  entry_t                e_wdata, e_rdata;

  skdet_ram #(.WIDTH($bits(key_t)), .DEPTH(NUM_KEYS)) u_key_ram (
    .clk(clk), .we(k_we), .addr(k_addr), .wdata(k_wdata), .rdata(k_rdata)
  );
  skdet_ram #(.WIDTH($bits(entry_t)), .DEPTH(NUM_KEYS*MAX_ENTRIES)) u_ent_ram (
    .clk(clk), .we(e_we), .addr(e_addr), .wdata(e_wdata), .rdata(e_rdata)
  );

  logic [10:0]        keys_use;
  logic signed [11:0] mid;
  logic [31:0]        prod;
  logic [16:0]        wsum;
  logic [15:0]        dsel;
  logic [16:0]        dsum;

  assign keys_use = (key_count_r > 11'(NUM_KEYS)) ? 11'(NUM_KEYS) : key_count_r;
  assign mid      = lo_r + ((hi_r - lo_r) >>> 1);
  assign prod     = decay_r * e_rdata.weight;
  assign dsel     = (e_rdata.deposit == 16'd0) ? ZERO_DEPOSIT : e_rdata.deposit;
  assign wsum     = {1'b0, prod[31:16]} + {1'b0, dsel};
  assign dsum     = {1'b0, e_rdata.deposit} + {1'b0, req_r.amount};

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = res_r;

  always_comb begin
    state_nxt     = state_r;
    games_nxt     = games_r;
    iter_nxt      = iter_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_valid_nxt = 1'b0;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    slot_nxt      = slot_r;
    cnt_nxt       = cnt_r;
    e_nxt         = e_r;
    k_we          = 1'b0;
    k_addr        = slot_r;
    k_wdata       = '{key: req_r.search_key,
                      cnt: (req_r.entry_count > 5'(MAX_ENTRIES)) ?
                           5'(MAX_ENTRIES) : req_r.entry_count};
    e_we          = 1'b0;
    e_addr        = {slot_r, e_r[IDX_W-1:0]};
    e_wdata       = e_rdata;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt  = in_item;
          res_nxt  = '0;
          res_nxt.iteration = iter_r;
          slot_nxt = in_item.slot;
          e_nxt    = {1'b0, in_item.entry_index};
          case (in_item.req_type)
            REQ_WR_KEY, REQ_WR_ENTRY: state_nxt = S_DONE;
            REQ_RD_ENTRY: begin
              e_addr    = {in_item.slot, in_item.entry_index};
              state_nxt = S_RDWAIT;
            end
            REQ_DEPOSIT: begin
              res_nxt.status = ST_NOT_FOUND;
              lo_nxt    = '0;
              hi_nxt    = $signed({1'b0, keys_use}) - 12'sd1;
              state_nxt = S_BS_RD;
            end
            REQ_GAME_END: begin
              if (games_r < interval_r) begin
                games_nxt = games_r + 8'd1;
                state_nxt = S_DONE;
              end else begin
                slot_nxt  = '0;
                state_nxt = S_SW_KRD;
              end
            end
            default: begin
              res_nxt.status = ST_RANGE;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end
      S_DONE: begin
        if (req_r.req_type == REQ_WR_KEY) begin
          k_we = 1'b1;
        end else if (req_r.req_type == REQ_WR_ENTRY) begin
          e_we    = 1'b1;
          e_wdata = '{move: req_r.move_code, weight: req_r.weight_in,
                      visits: req_r.visits_in, deposit: req_r.amount};
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_RDWAIT: begin
        res_nxt.move_out    = e_rdata.move;
        res_nxt.weight_out  = e_rdata.weight;
        res_nxt.visits_out  = e_rdata.visits;
        res_nxt.deposit_out = e_rdata.deposit;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_BS_RD: begin
        if (lo_r > hi_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          slot_nxt  = mid[SLOT_W-1:0];
          state_nxt = S_BS_WT;
        end
      end
      S_BS_WT: state_nxt = S_BS_CMP;
      S_BS_CMP: begin
        if (req_r.search_key == k_rdata.key) begin
          cnt_nxt   = k_rdata.cnt;
          e_nxt     = '0;
          state_nxt = S_SC_RD;
        end else begin
          if (req_r.search_key < k_rdata.key) begin
            hi_nxt = $signed({2'b0, slot_r}) - 12'sd1;
          end else begin
            lo_nxt = $signed({2'b0, slot_r}) + 12'sd1;
          end
          state_nxt = S_BS_RD;
        end
      end
      S_SC_RD: begin
        if (e_r >= cnt_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_SC_CHK;
        end
      end
      S_SC_CHK: begin
        if (e_rdata.move == req_r.move_code) begin
          e_we            = 1'b1;
          e_wdata.deposit = dsum[16] ? DEP_LIMIT : dsum[15:0];
          res_nxt.status  = ST_OK;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          e_nxt     = e_r + 5'd1;
          state_nxt = S_SC_RD;
        end
      end
      S_SW_KRD: begin
        if ({1'b0, slot_r} >= keys_use || keys_use == 11'd0) begin
          games_nxt         = '0;
          iter_nxt          = iter_r + 32'd1;
          res_nxt.swept     = 1'b1;
          res_nxt.iteration = iter_r + 32'd1;
          out_valid_nxt     = 1'b1;
          state_nxt         = S_IDLE;
        end else begin
          state_nxt = S_SW_KGT;
        end
      end
      S_SW_KGT: begin
        cnt_nxt   = k_rdata.cnt;
        e_nxt     = '0;
        state_nxt = S_SW_ERD;
      end
      S_SW_ERD: begin
        if (e_r >= cnt_r) begin
          if (slot_r == SLOT_W'(NUM_KEYS - 1)) begin
            games_nxt         = '0;
            iter_nxt          = iter_r + 32'd1;
            res_nxt.swept     = 1'b1;
            res_nxt.iteration = iter_r + 32'd1;
            out_valid_nxt     = 1'b1;
            state_nxt         = S_IDLE;
          end else begin
            slot_nxt  = slot_r + SLOT_W'(1);
            state_nxt = S_SW_KRD;
          end
        end else begin
          state_nxt = S_SW_EWR;
        end
      end
      S_SW_EWR: begin
        e_we            = 1'b1;
        e_wdata.weight  = wsum[16] ? 16'hFFFF :
                          (wsum[15:0] == 16'd0 ? 16'd1 : wsum[15:0]);
        e_wdata.deposit = '0;
        e_nxt           = e_r + 5'd1;
        state_nxt       = S_SW_ERD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      key_count_r <= '0;
      decay_r     <= DECAY_RESET;
      interval_r  <= INTERVAL_RST;
      games_r     <= '0;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      games_r     <= games_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEY_COUNT: key_count_r <= cfg_wdata[10:0];
          CFG_DECAY:     decay_r     <= cfg_wdata;
          CFG_INTERVAL:  interval_r  <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    res_r  <= res_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    slot_r <= slot_nxt;
    cnt_r  <= cnt_nxt;
    e_r    <= e_nxt;
  end

`ifndef ASSERT_OFF
  a_out_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_iter_step: assert property (@(posedge clk) disable iff (!rst_n)
    (iter_r != $past(iter_r)) |-> (iter_r == $past(iter_r) + 32'd1))
    else $error("iteration jumped");
  a_swept_iter: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.swept) |-> (out_item.iteration == iter_r))
    else $error("swept result iteration mismatch");
`endif

endmodule
